[sv/graph_vertex_merge_split_assert.svh]
// assertion macros for the vertex merge/split block
`ifndef GRAPH_VERTEX_MERGE_SPLIT_ASSERT_SVH
`define GRAPH_VERTEX_MERGE_SPLIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define GVMS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gvms assertion failed");
// checked at every edge, reset included
`define GVMS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gvms assertion failed");
`else
`define GVMS_ASSERT(lbl, prop)
`define GVMS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[sv/gvms_pkg.sv]
// shared types and constants of the vertex merge/split block
package gvms_pkg;

  localparam int MAX_V = 16;   // row count and row width
  localparam int IDX_W = 4;    // vertex index width
  localparam int CNT_W = 5;    // vertex count width
  localparam int ROW_W = 16;   // row field width

  localparam logic [2:0] CMD_CLEAR    = 3'd0;
  localparam logic [2:0] CMD_WRITE    = 3'd1;
  localparam logic [2:0] CMD_READ     = 3'd2;
  localparam logic [2:0] CMD_MERGE    = 3'd3;
  localparam logic [2:0] CMD_CONTRACT = 3'd4;
  localparam logic [2:0] CMD_SPLIT    = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_NO_EDGE = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // broadcast from the top level to every cell, strobes only for commands that pass checks
  typedef struct packed {
    logic             clr;
    logic             wr;
    logic             mrg;
    logic             spl;
    logic [IDX_W-1:0] u;
    logic [IDX_W-1:0] v;
    logic [CNT_W-1:0] n;
    logic [ROW_W-1:0] bits;
    logic [ROW_W-1:0] row_v;
  } ctl_t;

endpackage

[sv/gvms_req_if.sv]
// command channel interface
interface gvms_req_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  cmd;
  logic [gvms_pkg::IDX_W-1:0]  first_vertex;
  logic [gvms_pkg::IDX_W-1:0]  second_vertex;
  logic [gvms_pkg::ROW_W-1:0]  row_bits;
  logic [gvms_pkg::CNT_W-1:0]  new_count;

  modport source (output valid, cmd, first_vertex, second_vertex, row_bits, new_count,
                  input ready);
  modport sink (input valid, cmd, first_vertex, second_vertex, row_bits, new_count,
                output ready);
endinterface

[sv/gvms_rsp_if.sv]
// result channel interface
interface gvms_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [gvms_pkg::ROW_W-1:0]  row_out;
  logic [gvms_pkg::CNT_W-1:0]  vertex_count;

  modport source (output valid, status, row_out, vertex_count, input ready);
  modport sink (input valid, status, row_out, vertex_count, output ready);
endinterface

[sv/gvms_cell.sv]
// one matrix row cell: holds a row and hands its merged form to the cell below
module gvms_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [gvms_pkg::IDX_W-1:0] idx,
  input  gvms_pkg::ctl_t             ctl,
  input  logic [gvms_pkg::ROW_W-1:0] nbr_merged,
  output logic [gvms_pkg::ROW_W-1:0] row,
  output logic [gvms_pkg::ROW_W-1:0] merged
);

  logic [gvms_pkg::ROW_W-1:0] row_next;
  logic [gvms_pkg::ROW_W-1:0] folded;
  logic [gvms_pkg::ROW_W-1:0] mask;
  logic                       col;

  // row after folding v into u, before dropping column v
  always_comb begin
    folded = row;
    if (idx == ctl.u) begin
      folded = row | ctl.row_v;
      col    = row[ctl.u] | ctl.row_v[ctl.v];
    end else begin
      col    = row[ctl.u] | row[ctl.v];
    end
    folded[ctl.u] = col;
  end

  // drop column v, higher bits move down
  always_comb begin
    for (int j = 0; j < gvms_pkg::ROW_W; j++) begin
      if (j < int'(ctl.v)) begin
        merged[j] = folded[j];
      end else if (j + 1 < gvms_pkg::ROW_W) begin
        merged[j] = folded[j+1];
      end else begin
        merged[j] = 1'b0;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < gvms_pkg::ROW_W; j++) begin
      mask[j] = (gvms_pkg::CNT_W'(j) < ctl.n);
    end
  end

  always_comb begin
    row_next = row;
    if (ctl.clr) begin
      row_next = '0;
    end else if (ctl.wr) begin
      if (idx == ctl.u) row_next = ctl.bits & mask;
    end else if (ctl.mrg) begin
      row_next = (idx >= ctl.v) ? nbr_merged : merged;
    end else if (ctl.spl) begin
      if (idx == ctl.v) begin
        row_next = row | (gvms_pkg::ROW_W'(1) << ctl.n);
      end else if ({1'b0, idx} == ctl.n) begin
        row_next = gvms_pkg::ROW_W'(1) << ctl.v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else begin
      row <= row_next;
    end
  end

endmodule

[sv/graph_vertex_merge_split.sv]
// top level of the vertex merge/split block: a chain of sixteen row cells
//
// req carries one command per transfer: clear and set size, write row, read row,
// merge, contract and split, with vertex indexes, a row and a new count.
// rsp carries one result per command: status, the row read back and the
// vertex count after the command.
// a command is checked and applied in the cycle of its transfer; every cell
// updates its row at once, taking its neighbor's merged row when a merge
// deletes a vertex at or below it. the result sits in an output register and
// appears on rsp in the cycle after the req transfer.
// throughput is one command per cycle while rsp takes each result;
// req stays ready while the output register is empty or being emptied, so a
// stalled receiver stops new commands after the one result it holds.
// reset (rst, synchronous) clears every row, the vertex count and the
// valid flag of the output register.
`include "graph_vertex_merge_split_assert.svh"

module graph_vertex_merge_split (
  input  logic      clk,
  input  logic      rst,
  gvms_req_if.sink  req,
  gvms_rsp_if.source rsp
);

  localparam int MAX_V = gvms_pkg::MAX_V;

  logic [gvms_pkg::ROW_W-1:0] rows   [MAX_V];
  logic [gvms_pkg::ROW_W-1:0] merged [MAX_V];
  logic [gvms_pkg::ROW_W-1:0] nbr    [MAX_V];

  logic [gvms_pkg::CNT_W-1:0] count;
  logic [gvms_pkg::CNT_W-1:0] count_next;

  logic                       req_fire;
  logic [1:0]                 status_next;
  logic [gvms_pkg::ROW_W-1:0] row_out_next;
  logic [gvms_pkg::ROW_W-1:0] row_u;
  logic [gvms_pkg::ROW_W-1:0] row_v;
  logic                       u_ok;
  logic                       v_ok;
  logic                       stray_bits;
  gvms_pkg::ctl_t             ctl;

  // output register frees up when empty or when its result transfers
  assign req.ready = !rsp.valid || rsp.ready;
  assign req_fire  = req.valid && req.ready;

  assign row_u = rows[req.first_vertex];
  assign row_v = rows[req.second_vertex];
  assign u_ok  = {1'b0, req.first_vertex} < count;
  assign v_ok  = {1'b0, req.second_vertex} < count;

  // command checks and result
  always_comb begin
    status_next  = gvms_pkg::ST_OK;
    row_out_next = '0;
    ctl          = '0;
    ctl.u        = req.first_vertex;
    ctl.v        = req.second_vertex;
    ctl.n        = count;
    ctl.bits     = req.row_bits;
    ctl.row_v    = row_v;
    case (req.cmd)
      gvms_pkg::CMD_CLEAR: begin
        if (req.new_count > gvms_pkg::CNT_W'(MAX_V)) status_next = gvms_pkg::ST_BAD;
        else ctl.clr = req_fire;
      end
      gvms_pkg::CMD_WRITE: begin
        if (!u_ok) status_next = gvms_pkg::ST_BAD;
        else ctl.wr = req_fire;
      end
      gvms_pkg::CMD_READ: begin
        if (!u_ok) status_next = gvms_pkg::ST_BAD;
        else row_out_next = row_u;
      end
      gvms_pkg::CMD_MERGE, gvms_pkg::CMD_CONTRACT: begin
        if (!u_ok || !v_ok || req.first_vertex == req.second_vertex) begin
          status_next = gvms_pkg::ST_BAD;
        end else if (req.cmd == gvms_pkg::CMD_CONTRACT && !row_u[req.second_vertex]) begin
          status_next = gvms_pkg::ST_NO_EDGE;
        end else begin
          ctl.mrg = req_fire;
        end
      end
      gvms_pkg::CMD_SPLIT: begin
        if (!v_ok) status_next = gvms_pkg::ST_BAD;
        else if (count >= gvms_pkg::CNT_W'(MAX_V)) status_next = gvms_pkg::ST_FULL;
        else ctl.spl = req_fire;
      end
      default: begin
        // unused codes change nothing
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (ctl.clr) count_next = req.new_count;
    else if (ctl.mrg) count_next = count - 1'b1;
    else if (ctl.spl) count_next = count + 1'b1;
  end

  // row cells, each fed by the merged row of the cell above
  for (genvar gi = 0; gi < MAX_V; gi++) begin : g_cell
    if (gi == MAX_V - 1) begin : g_last
      assign nbr[gi] = '0;
    end else begin : g_mid
      assign nbr[gi] = merged[gi+1];
    end
    gvms_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .idx        (gvms_pkg::IDX_W'(gi)),
      .ctl        (ctl),
      .nbr_merged (nbr[gi]),
      .row        (rows[gi]),
      .merged     (merged[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (req_fire) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  // result payload, loaded with each req transfer
  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp.status       <= status_next;
      rsp.row_out      <= row_out_next;
      rsp.vertex_count <= count_next;
    end
  end

  // rows at or above the count must stay empty
  always_comb begin
    stray_bits = 1'b0;
    for (int i = 0; i < MAX_V; i++) begin
      if (gvms_pkg::CNT_W'(i) >= count) stray_bits = stray_bits | (|rows[i]);
    end
  end

  `GVMS_ASSERT(a_count_range, count <= gvms_pkg::CNT_W'(MAX_V))
  `GVMS_ASSERT(a_rows_beyond_empty, !stray_bits)
  `GVMS_ASSERT(a_count_only_on_transfer, !req_fire |=> $stable(count))
  `GVMS_ASSERT(a_full_only_split, req_fire && status_next == gvms_pkg::ST_FULL |-> req.cmd == gvms_pkg::CMD_SPLIT)
  `GVMS_ASSERT(a_rsp_drains, rsp.valid && rsp.ready && !req_fire |=> !rsp.valid)

endmodule
